// ===== design/i2scl_pkg.sv =====
// Shared types and constants for the stereo serial codec link.
`timescale 1ns / 1ps

package i2scl_pkg;

	localparam int MAX_FRAME_BITS_DEF = 32;
	localparam int SAMPLE_W = 32;
	localparam int CNT_W = 6;

	// slot placement codes
	localparam logic [1:0] FMT_I2S = 2'd0;
	localparam logic [1:0] FMT_LJ  = 2'd1;
	localparam logic [1:0] FMT_RJ  = 2'd2;

	// register indexes on the APB port
	localparam logic [2:0] REG_FORMAT       = 3'd0;
	localparam logic [2:0] REG_FIELD_BITS   = 3'd1;
	localparam logic [2:0] REG_FRAME_BITS   = 3'd2;
	localparam logic [2:0] REG_SIGNED_MODES = 3'd3;
	localparam logic [2:0] REG_ENABLE_POL   = 3'd4;

	typedef struct packed {
		logic [1:0]       format;
		logic [CNT_W-1:0] field_bits;
		logic [CNT_W-1:0] frame_bits;
		logic [3:0]       signed_modes;
		logic             enable_active_low;
	} cfg_t;

	typedef struct packed {
		logic                       serial_out;
		logic                       lr_select;
		logic                       enable_out;
		logic                       rx_valid;
		logic                       rx_channel;
		logic signed [SAMPLE_W-1:0] rx_sample;
	} tick_res_t;

endpackage

// ===== design/i2scl_core.sv =====
// Frame sequencer and sample encode/decode for one bit clock tick.
`timescale 1ns / 1ps

module i2scl_core #(
	parameter int MAX_FRAME_BITS = i2scl_pkg::MAX_FRAME_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  i2scl_pkg::cfg_t                        cfg,
	input  logic                                   advance,
	input  logic                                   start_req,
	input  logic signed [i2scl_pkg::SAMPLE_W-1:0]  tx_left,
	input  logic signed [i2scl_pkg::SAMPLE_W-1:0]  tx_right,
	input  logic                                   serial_in,
	output i2scl_pkg::tick_res_t                   res
);

	localparam int W = i2scl_pkg::SAMPLE_W;
	localparam int CW = i2scl_pkg::CNT_W;
	localparam int FRAME_LIM = (MAX_FRAME_BITS < W) ? MAX_FRAME_BITS : W;
	localparam logic [CW-1:0] FRAME_LIM_C = CW'(FRAME_LIM);

	function automatic logic [W-1:0] low_mask(input logic [CW-1:0] n);
		logic [W:0] t;
		t = ({{W{1'b0}}, 1'b1} << n) - {{W{1'b0}}, 1'b1};
		return t[W-1:0];
	endfunction

	function automatic logic [W-1:0] encode(input logic [W-1:0] raw, input logic sgn,
			input logic [CW-1:0] fr, input logic [CW-1:0] fi, input logic [CW-1:0] sh);
		logic [W-1:0] fm;
		logic [W-1:0] top;
		logic [W-1:0] code;
		logic signed [W:0] sv;
		logic signed [W:0] lim;
		fm  = low_mask(fi);
		top = {{(W-1){1'b0}}, 1'b1} << (fi - CW'(1));
		sv  = $signed({raw[W-1], raw});
		lim = -$signed({1'b0, top});
		if (sgn) begin
			code = (sv < lim) ? top : (raw & fm);
		end else begin
			code = (raw ^ top) & fm;
		end
		return (code << sh) & low_mask(fr);
	endfunction

	function automatic logic [W-1:0] decode(input logic [W-1:0] word, input logic sgn,
			input logic [CW-1:0] fi, input logic [CW-1:0] sh);
		logic [W-1:0] fm;
		logic [W-1:0] top;
		logic [W-1:0] code;
		fm   = low_mask(fi);
		top  = {{(W-1){1'b0}}, 1'b1} << (fi - CW'(1));
		code = (word >> sh) & fm;
		if (sgn) begin
			if ((code & top) != '0) code = code | ~fm;
		end else begin
			code = code ^ top;
		end
		return code;
	endfunction

	logic          frame_active_q;
	logic          channel_q;
	logic [CW-1:0] bit_count_q;
	logic [W-1:0]  tx_shift_q;
	logic [W-1:0]  rx_shift_q;
	logic [W-1:0]  right_hold_q;

	logic [CW-1:0] fr, fi, sh, fr_m1;
	logic [W-1:0]  fr_mask;
	logic [W-1:0]  enc_left, enc_right;
	logic          active, ch, last;
	logic [W-1:0]  tx_cur, rx_cur, hold_cur, tx_nxt, rx_nxt;
	logic [CW-1:0] bc_cur;

	// effective frame and field widths, then slot alignment
	always_comb begin
		fr = cfg.frame_bits;
		if (fr == '0) fr = CW'(1);
		if (fr > FRAME_LIM_C) fr = FRAME_LIM_C;
		fi = cfg.field_bits;
		if (fi == '0) fi = CW'(1);
		if (fi > fr) fi = fr;
		case (cfg.format)
			i2scl_pkg::FMT_I2S: sh = (fr > fi) ? (fr - fi - CW'(1)) : '0;
			i2scl_pkg::FMT_LJ:  sh = fr - fi;
			default:            sh = '0;
		endcase
		fr_m1   = fr - CW'(1);
		fr_mask = low_mask(fr);
	end

	assign enc_left  = encode(tx_left, cfg.signed_modes[0], fr, fi, sh);
	assign enc_right = encode(tx_right, cfg.signed_modes[1], fr, fi, sh);

	// a start tick is also the first bit of the left slot
	assign active   = frame_active_q || start_req;
	assign ch       = frame_active_q ? channel_q : 1'b0;
	assign bc_cur   = frame_active_q ? bit_count_q : '0;
	assign tx_cur   = frame_active_q ? tx_shift_q : enc_left;
	assign rx_cur   = frame_active_q ? rx_shift_q : '0;
	assign hold_cur = frame_active_q ? right_hold_q : enc_right;
	assign tx_nxt   = (tx_cur << 1) & fr_mask;
	assign rx_nxt   = ((rx_cur << 1) | {{(W-1){1'b0}}, serial_in}) & fr_mask;
	assign last     = (bc_cur >= fr_m1);

	always_comb begin
		res = '0;
		res.enable_out = cfg.enable_active_low;
		if (active) begin
			res.serial_out = tx_cur[fr_m1[4:0]];
			res.lr_select  = (cfg.format == i2scl_pkg::FMT_I2S) ? ch : ~ch;
			res.enable_out = ~cfg.enable_active_low;
			if (last) begin
				res.rx_valid   = 1'b1;
				res.rx_channel = ch;
				res.rx_sample  = decode(rx_nxt, cfg.signed_modes[{1'b1, ch}], fi, sh);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_active_q <= 1'b0;
			channel_q      <= 1'b0;
			bit_count_q    <= '0;
			tx_shift_q     <= '0;
			rx_shift_q     <= '0;
			right_hold_q   <= '0;
		end else if (advance && active) begin
			right_hold_q <= hold_cur;
			if (last) begin
				bit_count_q <= '0;
				rx_shift_q  <= '0;
				if (!ch) begin
					frame_active_q <= 1'b1;
					channel_q      <= 1'b1;
					tx_shift_q     <= hold_cur;
				end else begin
					frame_active_q <= 1'b0;
					channel_q      <= 1'b0;
					tx_shift_q     <= '0;
				end
			end else begin
				frame_active_q <= 1'b1;
				channel_q      <= ch;
				bit_count_q    <= bc_cur + CW'(1);
				tx_shift_q     <= tx_nxt;
				rx_shift_q     <= rx_nxt;
			end
		end
	end

endmodule

// ===== design/i2s_stereo_serial_codec_link.sv =====
// Top level of the stereo serial codec link: stream ports, APB registers, result register.
`timescale 1ns / 1ps

// Bit-clock master for a stereo converter link. Each transfer on the s_ side
// is one bit clock tick: a start request while idle latches both samples and
// begins a frame (left slot, then right slot, msb first); serial_in is the
// bit sampled from the converter on that tick. Each accepted tick yields one
// transfer on the m_ side carrying the pin levels for the tick and, on the
// last tick of a slot, the decoded received sample with its channel.
// m_tvalid rises in the cycle after the input transfer; while the receiver keeps up,
// one tick is taken every cycle. The whole tick (encode, shift, decode) is settled
// by the logic between the core's state and the result register.
// When the receiver stalls, the result register holds and s_tready drops
// until it is drained, so no result is lost; a tick is taken in the same
// cycle the held result leaves.
// Reset clears the frame state and loads the register defaults: I2S,
// 16-bit field, 32-bit slot, unsigned channels, active-high enable.
// Write the registers only while no frame is running.
module i2s_stereo_serial_codec_link #(
	parameter int MAX_FRAME_BITS = i2scl_pkg::MAX_FRAME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// tick input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // start_req[0], tx_left[32:1], tx_right[64:33],
	                              // serial_in[65], zero[71:66]
	// tick result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // serial_out[0], lr_select[1], enable_out[2],
	                              // rx_valid[3], rx_sample[35:4], zero[39:36]
	output logic [0:0]  m_tuser   // rx_channel[0]
);

	localparam int W = i2scl_pkg::SAMPLE_W;

	i2scl_pkg::cfg_t      cfg_q;
	i2scl_pkg::tick_res_t res;
	logic                 accept;
	logic                 m_valid_q;
	logic [39:0]          m_data_q;
	logic                 m_chan_q;
	logic                 wr_en;
	logic [2:0]           reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	// register write; addresses past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.format            <= i2scl_pkg::FMT_I2S;
			cfg_q.field_bits        <= 6'd16;
			cfg_q.frame_bits        <= 6'd32;
			cfg_q.signed_modes      <= 4'd0;
			cfg_q.enable_active_low <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				i2scl_pkg::REG_FORMAT:       cfg_q.format            <= pwdata[1:0];
				i2scl_pkg::REG_FIELD_BITS:   cfg_q.field_bits        <= pwdata[5:0];
				i2scl_pkg::REG_FRAME_BITS:   cfg_q.frame_bits        <= pwdata[5:0];
				i2scl_pkg::REG_SIGNED_MODES: cfg_q.signed_modes      <= pwdata[3:0];
				i2scl_pkg::REG_ENABLE_POL:   cfg_q.enable_active_low <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			i2scl_pkg::REG_FORMAT:       prdata = {30'd0, cfg_q.format};
			i2scl_pkg::REG_FIELD_BITS:   prdata = {26'd0, cfg_q.field_bits};
			i2scl_pkg::REG_FRAME_BITS:   prdata = {26'd0, cfg_q.frame_bits};
			i2scl_pkg::REG_SIGNED_MODES: prdata = {28'd0, cfg_q.signed_modes};
			i2scl_pkg::REG_ENABLE_POL:   prdata = {31'd0, cfg_q.enable_active_low};
			default:                     prdata = 32'd0;
		endcase
	end

	// take a tick whenever the result register is empty or draining
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	i2scl_core #(
		.MAX_FRAME_BITS(MAX_FRAME_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.advance   (accept),
		.start_req (s_tdata[0]),
		.tx_left   (s_tdata[W:1]),
		.tx_right  (s_tdata[2*W:W+1]),
		.serial_in (s_tdata[2*W+1]),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result payload: load on each accepted tick, hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= {4'd0, res.rx_sample, res.rx_valid, res.enable_out,
				res.lr_select, res.serial_out};
			m_chan_q <= res.rx_channel;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_chan_q;

endmodule

// ===== verif/i2s_stereo_serial_codec_link_checker.sv =====
// Tick predictor and result checker for the stereo serial codec link.
`timescale 1ns / 1ps

module i2s_stereo_serial_codec_link_checker
	import i2scl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [0:0]  m_tuser,
	output int          mismatches,
	output int          outstanding,
	output logic        link_busy
);

	localparam int SLOT_LIMIT = (MAX_FRAME_BITS_DEF < 32) ? MAX_FRAME_BITS_DEF : 32;

	cfg_t        cfg;
	logic        link_on;
	logic        slot_ch;
	logic [5:0]  slot_bit;
	logic [31:0] tx_word;
	logic [31:0] rx_word;
	logic [31:0] right_word;
	tick_res_t   due_ticks[$];
	int          bad_cnt;

	function automatic logic [31:0] ones_below(int n);
		logic [63:0] m;
		m = (64'd1 << n) - 64'd1;
		return m[31:0];
	endfunction

	function automatic int slot_len();
		int f;
		f = cfg.frame_bits;
		if (f < 1) f = 1;
		if (f > SLOT_LIMIT) f = SLOT_LIMIT;
		return f;
	endfunction

	function automatic int sample_len(int fr);
		int f;
		f = cfg.field_bits;
		if (f < 1) f = 1;
		if (f > fr) f = fr;
		return f;
	endfunction

	function automatic int slot_offset(int fr, int fi);
		if (cfg.format == FMT_I2S) return (fr > fi) ? fr - fi - 1 : 0;
		if (cfg.format == FMT_LJ) return fr - fi;
		return 0;
	endfunction

	function automatic logic [31:0] pack_slot(logic [31:0] v, int ch);
		int          fr;
		int          fi;
		logic [31:0] fm;
		logic [31:0] top;
		logic [31:0] code;
		longint      sv;
		longint      tl;
		fr = slot_len();
		fi = sample_len(fr);
		fm = ones_below(fi);
		top = 32'd1 << (fi - 1);
		if (cfg.signed_modes[ch]) begin
			sv = $signed(v);
			tl = top;
			// clamp anything below the field's most negative code
			code = (sv < -tl) ? top : (v & fm);
		end else begin
			code = (v ^ top) & fm;
		end
		return (code << slot_offset(fr, fi)) & ones_below(fr);
	endfunction

	function automatic logic [31:0] unpack_slot(logic [31:0] w, int ch);
		int          fr;
		int          fi;
		logic [31:0] fm;
		logic [31:0] top;
		logic [31:0] code;
		fr = slot_len();
		fi = sample_len(fr);
		fm = ones_below(fi);
		top = 32'd1 << (fi - 1);
		code = (w >> slot_offset(fr, fi)) & fm;
		if (cfg.signed_modes[2 + ch]) begin
			if ((code & top) != 0) code = code | ~fm;
		end else begin
			code = code ^ top;
		end
		return code;
	endfunction

	task automatic predict_tick(input logic start, input logic [31:0] left,
			input logic [31:0] right, input logic sin, output tick_res_t r);
		int fr;
		fr = slot_len();
		r = '0;
		r.enable_out = cfg.enable_active_low;
		if (!link_on && start) begin
			link_on = 1'b1;
			slot_ch = 1'b0;
			slot_bit = '0;
			tx_word = pack_slot(left, 0);
			right_word = pack_slot(right, 1);
			rx_word = '0;
		end
		if (link_on) begin
			r.serial_out = tx_word[fr - 1];
			r.lr_select = (cfg.format == FMT_I2S) ? slot_ch : ~slot_ch;
			r.enable_out = ~cfg.enable_active_low;
			tx_word = (tx_word << 1) & ones_below(fr);
			rx_word = ((rx_word << 1) | {31'd0, sin}) & ones_below(fr);
			if (slot_bit >= fr - 1) begin
				r.rx_valid = 1'b1;
				r.rx_channel = slot_ch;
				r.rx_sample = unpack_slot(rx_word, slot_ch);
				slot_bit = '0;
				rx_word = '0;
				if (!slot_ch) begin
					slot_ch = 1'b1;
					tx_word = right_word;
				end else begin
					slot_ch = 1'b0;
					link_on = 1'b0;
					tx_word = '0;
				end
			end else begin
				slot_bit = slot_bit + 6'd1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tick_res_t got;
		tick_res_t want;
		if (!arst_n) begin
			cfg.format = FMT_I2S;
			cfg.field_bits = 6'd16;
			cfg.frame_bits = 6'd32;
			cfg.signed_modes = 4'd0;
			cfg.enable_active_low = 1'b0;
			link_on = 1'b0;
			slot_ch = 1'b0;
			slot_bit = '0;
			tx_word = '0;
			rx_word = '0;
			right_word = '0;
			due_ticks.delete();
			bad_cnt = 0;
			mismatches <= 0;
			outstanding <= 0;
			link_busy <= 1'b0;
		end else begin
			// check the outgoing transfer before queueing the incoming one
			if (m_tvalid && m_tready) begin
				got.serial_out = m_tdata[0];
				got.lr_select = m_tdata[1];
				got.enable_out = m_tdata[2];
				got.rx_valid = m_tdata[3];
				got.rx_sample = m_tdata[35:4];
				got.rx_channel = m_tuser[0];
				if (due_ticks.size() == 0) begin
					$display("%0t: unexpected tick result %h", $time, got);
					bad_cnt++;
				end else begin
					want = due_ticks.pop_front();
					if (got !== want) begin
						$display("%0t: tick expected so=%b lr=%b en=%b v=%b ch=%b smp=%h",
							$time, want.serial_out, want.lr_select, want.enable_out,
							want.rx_valid, want.rx_channel, want.rx_sample);
						$display("%0t: tick actual   so=%b lr=%b en=%b v=%b ch=%b smp=%h",
							$time, got.serial_out, got.lr_select, got.enable_out,
							got.rx_valid, got.rx_channel, got.rx_sample);
						bad_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_tick(s_tdata[0], s_tdata[32:1], s_tdata[64:33], s_tdata[65], want);
				due_ticks.push_back(want);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_FORMAT:       cfg.format = pwdata[1:0];
					REG_FIELD_BITS:   cfg.field_bits = pwdata[5:0];
					REG_FRAME_BITS:   cfg.frame_bits = pwdata[5:0];
					REG_SIGNED_MODES: cfg.signed_modes = pwdata[3:0];
					REG_ENABLE_POL:   cfg.enable_active_low = pwdata[0];
					default: ;
				endcase
			end
			mismatches <= bad_cnt;
			outstanding <= due_ticks.size();
			link_busy <= link_on;
		end
	end

endmodule

// ===== verif/i2s_stereo_serial_codec_link_test.sv =====
// Top of the codec link testbench: clock, reset, register setup, tick stimulus and verdict.
`timescale 1ns / 1ps

module i2s_stereo_serial_codec_link_test;
	import i2scl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 9;
	localparam int PHASE_TICKS = 62;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;

	int   mismatches;
	int   outstanding;
	logic link_busy;

	// idle percentages for each side, and the request for a long receiver hold-off
	int   send_idle_pct;
	int   rcv_idle_pct;
	logic hold_off;
	// effective sample width of the current setting, to aim samples at its edges
	int   cur_width;
	int   cycle_cnt;

	i2s_stereo_serial_codec_link u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	i2s_stereo_serial_codec_link_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.link_busy   (link_busy)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog: count cycles and give up well past the slowest correct run.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("i2s_stereo_serial_codec_link: mismatch");
		$finish;
	end

	// Receiver side: take results with random stalls, or hold off for a long
	// stretch on request so the result register fills and s_tready drops.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// One APB write: setup cycle, then access cycle; pready is always high,
	// so the register takes the value at the edge that ends the access.
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write every register and track the effective sample width.
	task automatic set_link(input logic [1:0] fmt, input int field, input int frame,
			input logic [3:0] smodes, input logic en_low);
		int fr;
		fr = frame;
		if (fr < 1) fr = 1;
		if (fr > 32) fr = 32;
		cur_width = field;
		if (cur_width < 1) cur_width = 1;
		if (cur_width > fr) cur_width = fr;
		reg_write(REG_FORMAT, {30'd0, fmt});
		reg_write(REG_FIELD_BITS, field);
		reg_write(REG_FRAME_BITS, frame);
		reg_write(REG_SIGNED_MODES, {28'd0, smodes});
		reg_write(REG_ENABLE_POL, {31'd0, en_low});
	endtask

	// Offer one tick and hold it until the transfer; then maybe leave a gap.
	task automatic send_tick(input logic start, input logic [31:0] left,
			input logic [31:0] right, input logic sin);
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, sin, right, left, start};
		do @(posedge clk); while (!s_tready);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected result is in, plus a margin.
	task automatic wait_results();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Run out any frame in progress with idle ticks so registers can change.
	task automatic close_frame();
		wait_results();
		while (link_busy) begin
			send_tick(1'b0, $urandom, $urandom, 1'($urandom_range(0, 1)));
			wait_results();
		end
	endtask

	// Aim samples at the field edges often: saturation bound, top code, extremes.
	function automatic logic [31:0] pick_sample(int width);
		logic [31:0] top;
		logic [63:0] fm;
		top = 32'd1 << (width - 1);
		fm = (64'd1 << width) - 64'd1;
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return ~top + 32'd1;
			3: return ~top;
			4: return top - 32'd1;
			5: return $urandom & fm[31:0];
			6: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin : stimulus
		logic [7:0]  sin_pat;
		logic [1:0]  fmt;
		int          frame;
		int          field;
		int          i;
		int          p;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_off = 1'b0;
		send_idle_pct = 7;
		rcv_idle_pct = 64;
		cur_width = 16;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// I2S with frame equal to field (no delay shift): saturate a signed
		// left, push max positive right, keep start high through the frame so
		// starts while busy are ignored.
		set_link(FMT_I2S, 4, 4, 4'b0101, 1'b0);
		sin_pat = 8'b1011_0010;
		for (i = 0; i < 8; i++)
			send_tick(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, sin_pat[i]);
		close_frame();

		// Unused format code, zero frame and field (both act as one bit),
		// active-low enable, one idle tick first.
		set_link(2'd3, 0, 0, 4'b1010, 1'b1);
		send_tick(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_tick(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		send_tick(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0);
		send_tick(1'b1, 32'h0000_0000, 32'h8000_0000, 1'b0);
		send_tick(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		close_frame();

		// Left-justified with the field above the frame (clamped to it), all
		// channels signed, left just below the most negative code.
		set_link(FMT_LJ, 40, 3, 4'hF, 1'b0);
		sin_pat = 8'b0110_1101;
		for (i = 0; i < 7; i++)
			send_tick(i != 6, 32'hFFFF_FFFB, 32'h0000_0003, sin_pat[i]);
		close_frame();

		// Random phases: three idling regimes, one setting per phase, the
		// first two and the last fixed at the extremes.
		for (p = 0; p < PHASES; p++) begin
			if (p < 3) begin
				send_idle_pct = 7;
				rcv_idle_pct = 64;
			end else if (p < 6) begin
				send_idle_pct = 64;
				rcv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			case (p)
				0: set_link(FMT_I2S, 32, 32, 4'hF, 1'b0);
				1: set_link(FMT_LJ, 1, 1, 4'h0, 1'b1);
				8: set_link(FMT_RJ, 63, 63, 4'h5, 1'b1);
				default: begin
					fmt = 2'($urandom_range(0, 3));
					frame = ($urandom_range(99) < 60) ? $urandom_range(1, 8)
						: $urandom_range(0, 63);
					field = ($urandom_range(99) < 80) ? $urandom_range(0, frame + 1)
						: $urandom_range(0, 63);
					set_link(fmt, field, frame, 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)));
				end
			endcase
			for (i = 0; i < PHASE_TICKS; i++) begin
				// long receiver hold-off while ticks keep coming
				if (p == 7 && i == 10) hold_off = 1'b1;
				// pause the sender until every result is back
				if (p == 4 && i == PHASE_TICKS / 2) wait_results();
				send_tick($urandom_range(99) < 80, pick_sample(cur_width),
					pick_sample(cur_width), 1'($urandom_range(0, 1)));
			end
			close_frame();
		end

		wait_results();
		if (mismatches == 0) begin
			$display("i2s_stereo_serial_codec_link: match");
		end else begin
			$display("i2s_stereo_serial_codec_link: mismatch");
		end
		$finish;
	end

endmodule
